### src/tkws_pkg.sv
`default_nettype none
package tkws_pkg;

	localparam int DEF_MAX_K = 16;
	localparam int CAP_W = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
	localparam int ID_W = 20;
	localparam int WGT_W = 32;
	localparam int KEY_W = ID_W + WGT_W;

	typedef struct packed {
		logic [ID_W-1:0] item_id;
		logic signed [WGT_W-1:0] weight;
		logic included;
		logic end_of_scan;
	} in_item_t;

	typedef struct packed {
		logic [ID_W-1:0] kept_id;
		logic signed [WGT_W-1:0] kept_weight;
		logic empty_res;
		logic last_of_run;
	} out_item_t;

	typedef struct packed {
		logic [ID_W-1:0] item_id;
		logic signed [WGT_W-1:0] weight;
	} entry_t;

	typedef enum logic {
		ST_SCAN,
		ST_READOUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic update;
		logic load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic cnt_zero;
		logic cnt_one;
	} sts_t;

	// Order key: weight with its sign bit flipped, then id, compared unsigned.
	function automatic logic [KEY_W-1:0] entry_key(input entry_t e);
		entry_key = {~e.weight[WGT_W-1], e.weight[WGT_W-2:0], e.item_id};
	endfunction

endpackage
`default_nettype wire

### src/tkws_ctrl.sv
`default_nettype none
module tkws_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic item_valid,
	input wire logic item_eos,
	output logic item_stall,
	output logic res_valid,
	input wire logic res_stall,
	input wire tkws_pkg::sts_t sts,
	output tkws_pkg::cmd_t cmd
);

	tkws_pkg::state_t state_q, state_d;
	logic res_valid_q, res_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tkws_pkg::ST_SCAN;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			res_valid_q <= res_valid_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd.update = 1'b0;
		cmd.load = 1'b0;
		item_stall = 1'b1;
		res_valid_d = res_valid_q & res_stall;
		unique case (state_q)
			tkws_pkg::ST_SCAN: begin
				item_stall = 1'b0;
				if (item_valid) begin
					cmd.update = 1'b1;
					if (item_eos) begin
						state_d = tkws_pkg::ST_READOUT;
					end
				end
			end
			tkws_pkg::ST_READOUT: begin
				// The output register takes a new item once it is free or being taken.
				if (!res_valid_q || !res_stall) begin
					cmd.load = 1'b1;
					res_valid_d = 1'b1;
					if (sts.cnt_zero || sts.cnt_one) begin
						state_d = tkws_pkg::ST_SCAN;
					end
				end
			end
			default: state_d = tkws_pkg::ST_SCAN;
		endcase
	end

	assign res_valid = res_valid_q;

endmodule
`default_nettype wire

### src/tkws_dp.sv
`default_nettype none
module tkws_dp #(
	parameter int MAX_K = tkws_pkg::DEF_MAX_K
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cap_we,
	input wire logic [tkws_pkg::CAP_W-1:0] cap_wdata,
	input wire tkws_pkg::in_item_t item,
	output tkws_pkg::out_item_t res,
	input wire tkws_pkg::cmd_t cmd,
	output tkws_pkg::sts_t sts
);

	localparam int CNT_W = $clog2(MAX_K + 1);
	localparam int CMP_W = (CNT_W > tkws_pkg::CAP_W) ? CNT_W : tkws_pkg::CAP_W;

	logic [tkws_pkg::CAP_W-1:0] capacity_q;
	logic [CNT_W-1:0] count_q;
	tkws_pkg::entry_t ent_q [MAX_K];
	tkws_pkg::out_item_t res_q;

	tkws_pkg::entry_t new_ent;
	logic [MAX_K:0] lt;
	logic [CMP_W-1:0] cap_ext, cnt_ext, cap_eff;
	logic cap_nz, below_cap, do_ins, do_rep, pop;

	assign new_ent.item_id = item.item_id;
	assign new_ent.weight = item.weight;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= tkws_pkg::CAP_RESET;
		end else if (cap_we) begin
			capacity_q <= cap_wdata;
		end
	end

	assign cap_ext = CMP_W'(capacity_q);
	assign cnt_ext = CMP_W'(count_q);
	assign cap_eff = (cap_ext > CMP_W'(MAX_K)) ? CMP_W'(MAX_K) : cap_ext;
	assign cap_nz = (cap_eff != '0);
	assign below_cap = (cnt_ext < cap_eff);

	assign do_ins = cmd.update && item.included && cap_nz && below_cap;
	// Once full, only a strictly greater weight displaces the smallest entry.
	assign do_rep = cmd.update && item.included && cap_nz && !below_cap &&
			(count_q != '0) && (item.weight > ent_q[0].weight);
	assign pop = cmd.load && (count_q != '0);

	// lt[i]: the new item sorts before cell i; empty cells count as larger.
	assign lt[MAX_K] = 1'b1;
	for (genvar i = 0; i < MAX_K; i++) begin : g_cmp
		assign lt[i] = (CNT_W'(i) >= count_q) ||
				(tkws_pkg::entry_key(new_ent) < tkws_pkg::entry_key(ent_q[i]));
	end

	for (genvar i = 0; i < MAX_K; i++) begin : g_cell
		tkws_pkg::entry_t above, below;
		logic first_gt;
		if (i == MAX_K - 1) begin : g_top
			assign above = ent_q[i];
		end else begin : g_mid
			assign above = ent_q[i+1];
		end
		if (i == 0) begin : g_bot
			assign below = new_ent;
			assign first_gt = 1'b1;
		end else begin : g_up
			assign below = ent_q[i-1];
			assign first_gt = !lt[i-1];
		end

		always_ff @(posedge clk) begin
			if (pop) begin
				ent_q[i] <= above;
			end else if (do_ins) begin
				if (lt[i]) begin
					ent_q[i] <= first_gt ? new_ent : below;
				end
			end else if (do_rep) begin
				if (!lt[i+1]) begin
					ent_q[i] <= above;
				end else if (!lt[i]) begin
					ent_q[i] <= new_ent;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (do_ins) begin
			count_q <= count_q + 1'b1;
		end else if (pop) begin
			count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			if (count_q == '0) begin
				res_q.kept_id <= '0;
				res_q.kept_weight <= '0;
				res_q.empty_res <= 1'b1;
				res_q.last_of_run <= 1'b1;
			end else begin
				res_q.kept_id <= ent_q[0].item_id;
				res_q.kept_weight <= ent_q[0].weight;
				res_q.empty_res <= 1'b0;
				res_q.last_of_run <= (count_q == CNT_W'(1));
			end
		end
	end

	assign res = res_q;
	assign sts.cnt_zero = (count_q == '0);
	assign sts.cnt_one = (count_q == CNT_W'(1));

endmodule
`default_nettype wire

### src/top_k_weight_selector_top.sv
// Channel    Direction  Handshake              Payload
// item       in         item_valid/item_stall  tkws_pkg::in_item_t
// res        out        res_valid/res_stall    tkws_pkg::out_item_t
// capacity   in         cap_we                 cap_wdata
//
// An item without end_of_scan is taken every cycle; the sorted row of cells
// updates in the cycle it is accepted.
// An end_of_scan item is followed by a readout of max(kept, 1) results, one
// result per cycle while res is not stalled, from the bottom cell, while
// item_stall is high.
// Reset empties the store at once (count to zero) and sets capacity to 16.
`default_nettype none
module top_k_weight_selector_top #(
	parameter int MAX_K = tkws_pkg::DEF_MAX_K
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cap_we,
	input wire logic [tkws_pkg::CAP_W-1:0] cap_wdata,
	input wire logic item_valid,
	output logic item_stall,
	input wire tkws_pkg::in_item_t item,
	output logic res_valid,
	input wire logic res_stall,
	output tkws_pkg::out_item_t res
);

	tkws_pkg::cmd_t cmd;
	tkws_pkg::sts_t sts;

	tkws_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_eos(item.end_of_scan),
		.item_stall(item_stall),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.sts(sts),
		.cmd(cmd)
	);

	tkws_dp #(
		.MAX_K(MAX_K)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cap_we(cap_we),
		.cap_wdata(cap_wdata),
		.item(item),
		.res(res),
		.cmd(cmd),
		.sts(sts)
	);

endmodule
`default_nettype wire

### verif/top_k_weight_selector_top_test.sv
`timescale 1ns / 1ps
module top_k_weight_selector_top_test;
	import tkws_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES = 20;
	localparam int RANDOM_ITEMS = 96;
	localparam int RESET_CYCLES = 12;

	logic clk;
	logic arst_n;
	logic cap_we;
	logic [CAP_W-1:0] cap_wdata;
	logic item_valid;
	logic item_stall;
	in_item_t item;
	logic res_valid;
	logic res_stall;
	out_item_t res;

	int gap_pct;
	int stall_pct;
	int quiet_cycles;

	top_k_weight_selector_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cap_we(cap_we),
		.cap_wdata(cap_wdata),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	// Keeps its own copy of the ranked store and the readouts it implies.
	class topk_tracker;
		logic [CAP_W-1:0] capacity;
		logic signed [WGT_W-1:0] kept_w[DEF_MAX_K];
		logic [ID_W-1:0] kept_i[DEF_MAX_K];
		int unsigned kept_n;
		out_item_t readout_q[$];
		int errors;

		function new();
			capacity = CAP_RESET;
			kept_n = 0;
			errors = 0;
		endfunction

		function bit ranks_below(input logic signed [WGT_W-1:0] wa, input logic [ID_W-1:0] ia,
				input logic signed [WGT_W-1:0] wb, input logic [ID_W-1:0] ib);
			if (wa != wb) begin
				return wa < wb;
			end
			return ia < ib;
		endfunction

		// Inserts into the sorted first n entries, shifting larger ones up.
		function void place(input int unsigned n, input logic signed [WGT_W-1:0] w,
				input logic [ID_W-1:0] id);
			int unsigned pos;
			pos = n;
			while (pos > 0 && ranks_below(w, id, kept_w[pos-1], kept_i[pos-1])) begin
				kept_w[pos] = kept_w[pos-1];
				kept_i[pos] = kept_i[pos-1];
				pos--;
			end
			kept_w[pos] = w;
			kept_i[pos] = id;
		endfunction

		function void take_item(input in_item_t it);
			int unsigned room;
			logic signed [WGT_W-1:0] w;
			out_item_t r;
			room = (capacity > DEF_MAX_K) ? DEF_MAX_K : capacity;
			w = it.weight;
			if (it.included && room > 0) begin
				if (kept_n < room) begin
					place(kept_n, w, it.item_id);
					kept_n++;
				end else if (kept_n > 0 && w > kept_w[0]) begin
					// The smallest entry drops out; the count stays as it is.
					for (int unsigned i = 1; i < kept_n; i++) begin
						kept_w[i-1] = kept_w[i];
						kept_i[i-1] = kept_i[i];
					end
					place(kept_n - 1, w, it.item_id);
				end
			end
			if (!it.end_of_scan) begin
				return;
			end
			if (kept_n == 0) begin
				r = '0;
				r.empty_res = 1'b1;
				r.last_of_run = 1'b1;
				readout_q = {readout_q, r};
				return;
			end
			for (int unsigned i = 0; i < kept_n; i++) begin
				r = '0;
				r.kept_id = kept_i[i];
				r.kept_weight = kept_w[i];
				r.last_of_run = (i + 1 == kept_n);
				readout_q = {readout_q, r};
			end
			kept_n = 0;
		endfunction

		task report(input string what, input logic [63:0] got, input logic [63:0] want);
			errors++;
			if (errors <= 40) begin
				$display("%0t: %s mismatch: got %0h, expected %0h", $time, what, got, want);
			end
		endtask

		task check_kept(input out_item_t r);
			out_item_t want;
			if (readout_q.size() == 0) begin
				report("unexpected result", 64'(r), 64'(0));
				return;
			end
			want = readout_q.pop_front();
			if (r.kept_id !== want.kept_id) begin
				report("kept_id", 64'(r.kept_id), 64'(want.kept_id));
			end
			if (r.kept_weight !== want.kept_weight) begin
				report("kept_weight", 64'(r.kept_weight), 64'(want.kept_weight));
			end
			if (r.empty_res !== want.empty_res) begin
				report("empty_res", 64'(r.empty_res), 64'(want.empty_res));
			end
			if (r.last_of_run !== want.last_of_run) begin
				report("last_of_run", 64'(r.last_of_run), 64'(want.last_of_run));
			end
		endtask
	endclass

	topk_tracker sb;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit chance(input int pct);
		return $urandom_range(99) < pct;
	endfunction

	always @(negedge clk) begin
		res_stall <= chance(stall_pct);
	end

	// Both handshakes are sampled here; the watchdog counts cycles without either.
	always @(posedge clk) begin
		bit moved;
		moved = 1'b0;
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				sb.take_item(item);
				moved = 1'b1;
			end
			if (res_valid && !res_stall) begin
				sb.check_kept(res);
				moved = 1'b1;
			end
		end
		quiet_cycles = moved ? 0 : quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic in_item_t make_item(input logic [ID_W-1:0] id,
			input logic [WGT_W-1:0] w, input logic inc, input logic eos);
		in_item_t it;
		it.item_id = id;
		it.weight = w;
		it.included = inc;
		it.end_of_scan = eos;
		return it;
	endfunction

	function automatic logic [WGT_W-1:0] pick_weight();
		case ($urandom_range(5))
			0: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			1, 2: return $signed($urandom_range(8)) - 4;
			3: return $signed($urandom) >>> $urandom_range(16, 8);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [ID_W-1:0] pick_id();
		return ID_W'(($urandom_range(3) == 0) ? $urandom_range(7) : $urandom_range(20'hFFFFF));
	endfunction

	function automatic logic [CAP_W-1:0] pick_capacity();
		case ($urandom_range(7))
			0: return '0;
			1: return 5'd31;
			2, 3: return CAP_W'($urandom_range(4, 1));
			default: return CAP_W'($urandom_range(16, 1));
		endcase
	endfunction

	task automatic send_item(input in_item_t it);
		while (chance(gap_pct)) begin
			@(negedge clk);
			item_valid <= 1'b0;
		end
		@(negedge clk);
		item <= it;
		item_valid <= 1'b1;
		do begin
			@(posedge clk);
		end while (item_stall);
	endtask

	// Holds the sender back until every readout item has come and the block has settled.
	task automatic drain_and_settle();
		do begin
			@(negedge clk);
			item_valid <= 1'b0;
		end while (sb.readout_q.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] v);
		drain_and_settle();
		cap_we <= 1'b1;
		cap_wdata <= v;
		sb.capacity = v;
		@(negedge clk);
		cap_we <= 1'b0;
	endtask

	task automatic random_scan(input int unsigned len);
		int unsigned retune_at;
		retune_at = chance(15) ? $urandom_range(len - 1) : len;
		for (int unsigned k = 0; k < len; k++) begin
			if (k == retune_at) begin
				write_capacity(pick_capacity());
			end
			send_item(make_item(pick_id(), pick_weight(), chance(85), k == len - 1));
		end
	endtask

	initial begin
		int unsigned sent;
		int unsigned len;
		sb = new();
		quiet_cycles = 0;
		gap_pct = 0;
		stall_pct = 0;
		arst_n = 1'b0;
		cap_we = 1'b0;
		cap_wdata = '0;
		item_valid = 1'b0;
		item = '0;
		res_stall = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// End of scan with nothing kept, on an item that is not included.
		send_item(make_item(20'd5, 32'h0, 1'b0, 1'b1));

		// Field extremes, a weight tie broken by id, an ignored item, and an
		// end-of-scan item that is itself kept.
		send_item(make_item(20'hFFFFF, 32'h7FFF_FFFF, 1'b1, 1'b0));
		send_item(make_item(20'd0, 32'h8000_0000, 1'b1, 1'b0));
		send_item(make_item(20'd7, 32'h0001_0000, 1'b1, 1'b0));
		send_item(make_item(20'd3, 32'h0001_0000, 1'b1, 1'b0));
		send_item(make_item(20'd9, 32'hFFFF_FFFF, 1'b0, 1'b0));
		send_item(make_item(20'd1, 32'h0001_8000, 1'b1, 1'b1));

		// Full store: an equal weight does not replace, a greater one does.
		write_capacity(5'd2);
		send_item(make_item(20'd1, 32'd100, 1'b1, 1'b0));
		send_item(make_item(20'd2, 32'd100, 1'b1, 1'b0));
		send_item(make_item(20'd0, 32'd100, 1'b1, 1'b0));
		send_item(make_item(20'd50, 32'd101, 1'b1, 1'b0));

		// Capacity zero ignores items but keeps what is stored.
		write_capacity(5'd0);
		send_item(make_item(20'd8, 32'h7FFF_FFFF, 1'b1, 1'b0));

		// Capacity lowered below the count: replacement only.
		write_capacity(5'd1);
		send_item(make_item(20'd4, 32'd200, 1'b1, 1'b0));
		send_item(make_item(20'd6, 32'd50, 1'b1, 1'b0));
		send_item(make_item(20'd11, 32'd0, 1'b0, 1'b1));
		send_item(make_item(20'd12, 32'd5, 1'b1, 1'b1));

		write_capacity(5'd0);
		send_item(make_item(20'd13, 32'd0, 1'b1, 1'b1));

		// Capacity above the store size saturates.
		write_capacity(5'd31);
		send_item(make_item(20'd20, 32'h8000_0000, 1'b1, 1'b0));
		send_item(make_item(20'd21, 32'h8000_0000, 1'b1, 1'b0));
		send_item(make_item(20'hFFFFF, 32'h8000_0000, 1'b1, 1'b1));

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					gap_pct = 0;
					stall_pct = 0;
					write_capacity(5'd31);
				end
				1: begin
					gap_pct = 88;
					stall_pct = 0;
					write_capacity(5'd3);
				end
				2: begin
					gap_pct = 0;
					stall_pct = 88;
					write_capacity(5'd16);
				end
				default: begin
					gap_pct = 38;
					stall_pct = 38;
					write_capacity(pick_capacity());
				end
			endcase
			sent = 0;
			while (sent < RANDOM_ITEMS / 4) begin
				// The first scan of a phase is long, 15 to 24 items, enough that it can overflow the store.
				len = (sent == 0 || chance(20)) ? $urandom_range(24, 15) : $urandom_range(10, 1);
				if (sent != 0 && chance(20)) begin
					write_capacity(pick_capacity());
				end
				random_scan(len);
				sent += len;
			end
		end

		drain_and_settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.readout_q.size() != 0) begin
			sb.report("missing results", 64'(sb.readout_q.size()), 64'(0));
		end
		if (sb.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule
